// File: hw/rtl/mkx_pkg.sv
// shared types, constants and s-box table for the magma ctr keystream block
package mkx_pkg;

    // cipher geometry
    localparam int ROUNDS         = 32;
    localparam int FORWARD_ROUNDS = 24;
    localparam int ROUND_W        = $clog2(ROUNDS);
    localparam int ROT_LEFT       = 11;
    localparam int BLOCK_W        = 64;
    localparam int HALF_W         = 32;
    localparam int COUNT_W        = 4;
    localparam int BYTES          = BLOCK_W / 8;
    localparam int CFG_INDEX_W    = 3;

    typedef logic [3:0] nib_t;

    // s-box rows, row 0 serves the least significant nibble
    localparam nib_t SBOX [0:7][0:15] = '{
        '{4'd12, 4'd4,  4'd6,  4'd2,  4'd10, 4'd5,  4'd11, 4'd9,
          4'd14, 4'd8,  4'd13, 4'd7,  4'd0,  4'd3,  4'd15, 4'd1},
        '{4'd6,  4'd8,  4'd2,  4'd3,  4'd9,  4'd10, 4'd5,  4'd12,
          4'd1,  4'd14, 4'd4,  4'd7,  4'd11, 4'd13, 4'd0,  4'd15},
        '{4'd11, 4'd3,  4'd5,  4'd8,  4'd2,  4'd15, 4'd10, 4'd13,
          4'd14, 4'd1,  4'd7,  4'd4,  4'd12, 4'd9,  4'd6,  4'd0},
        '{4'd12, 4'd8,  4'd2,  4'd1,  4'd13, 4'd4,  4'd15, 4'd6,
          4'd7,  4'd0,  4'd10, 4'd5,  4'd3,  4'd14, 4'd9,  4'd11},
        '{4'd7,  4'd15, 4'd5,  4'd10, 4'd8,  4'd1,  4'd6,  4'd13,
          4'd0,  4'd9,  4'd3,  4'd14, 4'd11, 4'd4,  4'd2,  4'd12},
        '{4'd5,  4'd13, 4'd15, 4'd6,  4'd9,  4'd2,  4'd12, 4'd10,
          4'd11, 4'd7,  4'd8,  4'd1,  4'd4,  4'd3,  4'd14, 4'd0},
        '{4'd8,  4'd14, 4'd2,  4'd5,  4'd6,  4'd9,  4'd1,  4'd12,
          4'd15, 4'd4,  4'd11, 4'd0,  4'd13, 4'd10, 4'd3,  4'd7},
        '{4'd1,  4'd7,  4'd14, 4'd13, 4'd0,  4'd5,  4'd8,  4'd3,
          4'd4,  4'd15, 4'd10, 4'd6,  4'd9,  4'd12, 4'd11, 4'd2}
    };

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_KEY_A     = 3'd0,
        CFG_KEY_B     = 3'd1,
        CFG_KEY_C     = 3'd2,
        CFG_KEY_D     = 3'd3,
        CFG_CTR_START = 3'd4
    } cfg_idx_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic               load;      // take the input beat, set up the counter block
        logic               step;      // run one feistel round
        logic               last;      // this round is the final one, no half swap
        logic               out_load;  // move the finished block into the output register
        logic [ROUND_W-1:0] round;     // round number of this step
    } cmd_t;

endpackage

// File: hw/rtl/mkx_ifs.sv
// valid/ready channel interfaces for input data beats and result beats
interface mkx_in_if
    import mkx_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [BLOCK_W-1:0] data_block;
    logic [COUNT_W-1:0] byte_count;
    logic               message_start;

    modport source (output valid, output data_block, output byte_count,
                    output message_start, input ready);
    modport sink   (input valid, input data_block, input byte_count,
                    input message_start, output ready);
endinterface

interface mkx_out_if
    import mkx_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [BLOCK_W-1:0] result_block;
    logic [COUNT_W-1:0] result_count;

    modport source (output valid, output result_block, output result_count, input ready);
    modport sink   (input valid, input result_block, input result_count, output ready);
endinterface

// File: hw/rtl/mkx_ctrl.sv
// controller: beat handshakes, round sequencing and output register valid
module mkx_ctrl
    import mkx_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t cmd
);

    state_t             state_reg, state_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_free;
    logic               last_round;

    assign out_free   = !out_valid_reg || out_ready;
    assign last_round = (round_reg == ROUND_W'(ROUNDS - 1));
    assign out_valid  = out_valid_reg;

    // state, round counter and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        round_next   = round_reg;
        in_ready     = 1'b0;
        cmd.load     = 1'b0;
        cmd.step     = 1'b0;
        cmd.last     = last_round;
        cmd.out_load = 1'b0;
        cmd.round    = round_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    round_next = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.step   = 1'b1;
                round_next = round_reg + ROUND_W'(1);
                if (last_round)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    in_ready     = 1'b1;
                    if (in_valid)
                    begin
                        cmd.load   = 1'b1;
                        round_next = '0;
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid: set on load, cleared when the beat is taken
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

`ifndef NO_ASSERTIONS
    // an accepted beat always starts the round sequence
    a_load_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_RUN && round_reg == '0))
        else $error("accepted beat did not start round sequence");

    // the final round always hands over to the done state
    a_last_round_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && last_round) |=> (state_reg == ST_DONE))
        else $error("final round did not finish the block");

    // no new beat while rounds are in flight
    a_no_accept_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> !in_ready)
        else $error("input ready while rounds in flight");

    // the output register is never overwritten while holding an untaken beat
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten");
`endif

endmodule

// File: hw/rtl/mkx_datapath.sv
// datapath: config registers, block counter, shared magma round unit, output register
module mkx_datapath
    import mkx_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [BLOCK_W-1:0]     cfg_data,
    input  cmd_t                   cmd,
    input  logic [BLOCK_W-1:0]     data_block,
    input  logic [COUNT_W-1:0]     byte_count,
    input  logic                   message_start,
    output logic [BLOCK_W-1:0]     result_block,
    output logic [COUNT_W-1:0]     result_count
);

    logic [BLOCK_W-1:0] key_a_reg, key_b_reg, key_c_reg, key_d_reg;
    logic [BLOCK_W-1:0] ctr_start_reg;
    logic [BLOCK_W-1:0] counter_reg;
    logic [BLOCK_W-1:0] ctr_block;
    logic [HALF_W-1:0]  hi_reg, hi_next;
    logic [HALF_W-1:0]  lo_reg, lo_next;
    logic [BLOCK_W-1:0] data_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_sat;
    logic [BLOCK_W-1:0] result_reg;
    logic [COUNT_W-1:0] result_count_reg;
    logic [BLOCK_W-1:0] byte_mask;
    logic [2:0]         key_sel;
    logic [BLOCK_W-1:0] key_word;
    logic [HALF_W-1:0]  round_key;
    logic [HALF_W-1:0]  sum;
    logic [HALF_W-1:0]  subst;
    logic [HALF_W-1:0]  rotated;
    logic [HALF_W-1:0]  feistel;

    // block to encipher: restart value at message start
    assign ctr_block = message_start ? ctr_start_reg : counter_reg;

    // config registers and block counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_a_reg     <= '0;
            key_b_reg     <= '0;
            key_c_reg     <= '0;
            key_d_reg     <= '0;
            ctr_start_reg <= '0;
            counter_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_KEY_A:     key_a_reg     <= cfg_data;
                    CFG_KEY_B:     key_b_reg     <= cfg_data;
                    CFG_KEY_C:     key_c_reg     <= cfg_data;
                    CFG_KEY_D:     key_d_reg     <= cfg_data;
                    CFG_CTR_START: ctr_start_reg <= cfg_data;
                    default:       ;
                endcase
            end
            if (cmd.load)
            begin
                counter_reg <= ctr_block + BLOCK_W'(1);
            end
        end
    end

    // round key: K0..K7 forward, then K7..K0 for the closing rounds
    always_comb
    begin
        if (cmd.round < ROUND_W'(FORWARD_ROUNDS))
        begin
            key_sel = cmd.round[2:0];
        end
        else
        begin
            key_sel = ~cmd.round[2:0];
        end
        case (key_sel[2:1])
            2'd0:    key_word = key_a_reg;
            2'd1:    key_word = key_b_reg;
            2'd2:    key_word = key_c_reg;
            default: key_word = key_d_reg;
        endcase
        round_key = key_sel[0] ? key_word[HALF_W-1:0] : key_word[BLOCK_W-1:HALF_W];
    end

    // round function: add key, s-box per nibble, rotate left
    always_comb
    begin
        sum = lo_reg + round_key;
        for (int i = 0; i < 8; i++)
        begin
            subst[4*i +: 4] = SBOX[i][sum[4*i +: 4]];
        end
        rotated = {subst[HALF_W-ROT_LEFT-1:0], subst[HALF_W-1:HALF_W-ROT_LEFT]};
        feistel = rotated ^ hi_reg;
    end

    // half update: load the counter block, then swap on every round but the last
    always_comb
    begin
        hi_next = hi_reg;
        lo_next = lo_reg;
        if (cmd.load)
        begin
            hi_next = ctr_block[BLOCK_W-1:HALF_W];
            lo_next = ctr_block[HALF_W-1:0];
        end
        else if (cmd.step)
        begin
            if (cmd.last)
            begin
                hi_next = feistel;
            end
            else
            begin
                hi_next = lo_reg;
                lo_next = feistel;
            end
        end
    end

    // byte count clamp to the block size
    assign count_sat = (byte_count > COUNT_W'(BYTES)) ? COUNT_W'(BYTES) : byte_count;

    // keep only the leading valid bytes
    always_comb
    begin
        for (int b = 0; b < BYTES; b++)
        begin
            byte_mask[BLOCK_W-1-8*b -: 8] = (COUNT_W'(b) < count_reg) ? 8'hFF : 8'h00;
        end
    end

    // working halves, captured beat and output register
    always_ff @(posedge clk)
    begin
        hi_reg <= hi_next;
        lo_reg <= lo_next;
        if (cmd.load)
        begin
            data_reg  <= data_block;
            count_reg <= count_sat;
        end
        if (cmd.out_load)
        begin
            result_reg       <= (data_reg ^ {hi_reg, lo_reg}) & byte_mask;
            result_count_reg <= count_reg;
        end
    end

    assign result_block = result_reg;
    assign result_count = result_count_reg;

endmodule

// File: hw/rtl/magma_ctr_keystream_xor.sv
// top level of the magma counter-mode keystream xor block
//
// Each input beat carries up to eight data bytes (first byte in the top
// bits) and is XORed with the Magma encipherment of a 64-bit block counter;
// bytes past the count read as zero and the counter then steps by one.
// message_start reloads the counter from counter_start before the beat.
// One shared round unit runs the 32 Feistel rounds one per clock, and a new
// beat is taken only once the rounds of the last one are done; the
// finished block sits in an output register, so a stalled output side does
// not hold back the next beat unless that register is still full at the end
// of its rounds. Key and counter_start registers are written through the cfg
// port; the user must write them only while the block is idle, the block itself does not enforce it.
module magma_ctr_keystream_xor
    import mkx_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    mkx_in_if.sink                 item,
    mkx_out_if.source              result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [BLOCK_W-1:0]     cfg_data
);

    cmd_t cmd;

    // sequencing and handshakes
    mkx_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd)
    );

    // cipher, counter and output data
    mkx_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .data_block    (item.data_block),
        .byte_count    (item.byte_count),
        .message_start (item.message_start),
        .result_block  (result.result_block),
        .result_count  (result.result_count)
    );

endmodule
